// ===== sv/sab_pkg.sv =====
`default_nettype none
package sab_pkg;

  localparam int MAX_SYMBOLS     = 32;
  localparam int MAX_STATES      = 4096;
  localparam int NEW_STATE_LIMIT = 127;

  // field widths
  localparam int REQ_W   = 2;
  localparam int SYMF_W  = 6;
  localparam int RULE_W  = 11;
  localparam int ROW_W   = 13;
  localparam int ENT_W   = 14;
  localparam int CNT_W   = 13;
  localparam int STAT_W  = 2;

  // storage geometry
  localparam int SYM_W   = $clog2(MAX_SYMBOLS);
  localparam int ST_W    = $clog2(MAX_STATES);
  localparam int TBL_AW  = SYM_W + ST_W;
  localparam int MARK_AW = ST_W + 1;
  localparam int NN_W    = $clog2(NEW_STATE_LIMIT + 2);
  localparam int MARK_W  = NN_W + 1;
  localparam int SPL_AW  = $clog2(NEW_STATE_LIMIT + 1);

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  localparam logic [REQ_W-1:0] REQ_LETTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REINIT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MANY = 2'd2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD, S_RD_W, S_FL, S_CLR,
    S_C_RD, S_C_Y, S_C_MK,
    S_M_RD, S_M_Y, S_M_MN, S_M_SPL, S_M_SRCH, S_M_SCMP,
    S_CP_SRC, S_CP_SW, S_CP_RD, S_CP_WR,
    S_P3_LST, S_P3_P, S_P3_V, S_P3_A, S_P3_B, S_COMMIT,
    S_F_LST, S_F_WR, S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/substring_automaton_builder.sv =====
`default_nettype none
// Channel  Dir  Beat contents (low bit first)
// in_      in   tuser: req_type[1:0] is_first[2]; tdata: symbol[5:0] rule_number[16:6]
//               read_state[29:17]; tlast: is_last
// out_     out  tuser: status[1:0]; tdata: entry_value[13:0] state_count[26:14]
// cfg_     in   wr_data: num_symbols, taken on every cycle with wr_en high
//
// One beat is worked at a time through a sequencer around a single-port
// transition memory (32 x 4096 entries). A read passes S_RD and S_RD_W; a
// first letter scans every state and marks each hit; a middle letter scans
// every state, with a list search per split, a copy of num_symbols entries
// per new state and a fix-up per listed state; a last letter writes each
// listed state. Reset and each reinitialize run a clearing pass that
// rewrites the whole table; no beat is taken meanwhile. A result waiting on
// out_tready does not stop the next in_ beat from being accepted.
module substring_automaton_builder (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [sab_pkg::IN_DATA_W-1:0]     in_tdata,   // symbol, rule_number, read_state
  input  wire  [sab_pkg::IN_USER_W-1:0]     in_tuser,   // req_type, is_first
  input  wire                               in_tlast,   // is_last
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [sab_pkg::OUT_DATA_W-1:0]    out_tdata,  // entry_value, state_count
  output logic [sab_pkg::OUT_USER_W-1:0]    out_tuser,  // status
  input  wire                               cfg_wr_en,
  input  wire  [sab_pkg::SYMF_W-1:0]        cfg_wr_data
);
  import sab_pkg::*;

  state_t state_r, state_nxt;

  // memories
  logic [ENT_W-1:0]  tbl_mem [2**TBL_AW];
  logic [MARK_W-1:0] mark_mem [2**MARK_AW];
  logic [ST_W-1:0]   list_mem [2**MARK_AW];
  logic [ST_W-1:0]   split_mem [2**SPL_AW];

  logic              tbl_re, tbl_we, mark_re, mark_we, list_re, list_we, split_re, split_we;
  logic [TBL_AW-1:0] tbl_addr;
  logic [ENT_W-1:0]  tbl_wdata, tbl_rd_r;
  logic [MARK_AW-1:0] mark_addr;
  logic [MARK_W-1:0] mark_wdata, mark_rd_r;
  logic [MARK_AW-1:0] list_addr;
  logic [ST_W-1:0]   list_wdata, list_rd_r;
  logic [SPL_AW-1:0] split_addr;
  logic [ST_W-1:0]   split_wdata, split_rd_r;

  // control and datapath registers
  logic [SYMF_W-1:0] num_sym_r;
  logic [TBL_AW-1:0] sweep_r;
  logic              init_req_r, mid_r, bank_r, mc_r, append_r, out_valid_r;
  logic [CNT_W-1:0]  ns_r, idx_r, len0_r, n2_r, j_r, y_r, z_r;
  logic [NN_W-1:0]   nn_r, k_r, a_r;
  logic [SYMF_W-1:0] ci_r;
  logic [SYM_W-1:0]  g_r;
  logic [RULE_W-1:0] rule_r;
  logic [ST_W-1:0]   row_r, src_r, p_r;
  logic [ENT_W-1:0]  entry_r, out_entry_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [STAT_W-1:0] err_r, out_stat_r;

  // input fields
  logic [REQ_W-1:0]  in_req;
  logic [SYMF_W-1:0] in_sym;
  logic              in_first, in_last;
  logic [RULE_W-1:0] in_rule;
  logic [ROW_W-1:0]  in_row;
  logic              in_fire;

  assign in_req   = in_tuser[1:0];
  assign in_first = in_tuser[2];
  assign in_last  = in_tlast;
  assign in_sym   = in_tdata[5:0];
  assign in_rule  = in_tdata[16:6];
  assign in_row   = in_tdata[29:17];
  assign in_fire  = in_tvalid && in_tready;

  // decode helpers
  logic [SYMF_W-1:0] nsym;
  logic              sym_ok, row_ok, letter_go, sweep_last;
  logic signed [ENT_W-1:0]  tbl_s, ns_s, neg_rule;
  logic signed [MARK_W-1:0] mark_s;
  logic              tgt_ok, idx_last, lst_last, split_hit, too_many, store_full;
  logic [NN_W-1:0]   nn_inc;
  logic [CNT_W:0]    z_sum;
  logic              cp_last_i, cp_last_k, p_ok, srch_hit;
  logic              bank_n;
  state_t            mid_adv_st, p3_start_st;

  always_comb begin
    if (num_sym_r == '0) begin
      nsym = SYMF_W'(1);
    end else if (num_sym_r > SYMF_W'(MAX_SYMBOLS)) begin
      nsym = SYMF_W'(MAX_SYMBOLS);
    end else begin
      nsym = num_sym_r;
    end
  end

  assign sym_ok     = (in_sym != '0) && (in_sym <= nsym);
  assign row_ok     = (in_row != '0) && (in_row <= ns_r);
  assign letter_go  = (in_req == REQ_LETTER) && (err_r == STAT_OK) && sym_ok;
  assign sweep_last = (sweep_r == {TBL_AW{1'b1}});
  assign tbl_s      = $signed(tbl_rd_r);
  assign ns_s       = $signed(ENT_W'(ns_r));
  assign neg_rule   = -$signed(ENT_W'(rule_r));
  assign mark_s     = $signed(mark_rd_r);
  assign tgt_ok     = (tbl_s > 0) && (tbl_s <= ns_s);
  assign idx_last   = ((idx_r + CNT_W'(1)) == ns_r);
  assign lst_last   = ((idx_r + CNT_W'(1)) == len0_r);
  assign split_hit  = ((mark_s == -1) && mc_r) || ((mark_s == 1) && !mc_r);
  assign nn_inc     = nn_r + NN_W'(1);
  assign too_many   = (nn_inc > NN_W'(NEW_STATE_LIMIT));
  assign z_sum      = {1'b0, ns_r} + (CNT_W+1)'(nn_inc);
  assign store_full = (z_sum > (CNT_W+1)'(MAX_STATES));
  assign cp_last_i  = ((ci_r + SYMF_W'(1)) == nsym);
  assign cp_last_k  = (k_r == nn_r);
  assign p_ok       = ((CNT_W'(list_rd_r) + CNT_W'(1)) <= ns_r);
  assign srch_hit   = (list_rd_r == y_r[ST_W-1:0] - ST_W'(1));
  assign bank_n     = ~bank_r;
  assign p3_start_st = (len0_r == '0) ? S_COMMIT : S_P3_LST;
  assign mid_adv_st  = !idx_last ? S_M_RD : ((nn_r == '0) ? p3_start_st : S_CP_SRC);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-ENT_W-CNT_W)'(0), out_cnt_r, out_entry_r};
  assign out_tuser  = out_stat_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (sweep_last) state_nxt = init_req_r ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          priority if (in_req == REQ_REINIT) begin
            state_nxt = S_INIT;
          end else if (in_req == REQ_READ) begin
            state_nxt = (sym_ok && row_ok) ? S_RD : S_DONE;
          end else if (!letter_go) begin
            state_nxt = S_DONE;
          end else if (in_first && in_last) begin
            state_nxt = S_FL;
          end else if (in_last) begin
            state_nxt = (len0_r == '0) ? S_DONE : S_F_LST;
          end else begin
            state_nxt = S_CLR;
          end
        end
      end
      S_RD:    state_nxt = S_RD_W;
      S_RD_W:  state_nxt = S_DONE;
      S_FL:    if (idx_last) state_nxt = S_DONE;
      S_CLR:   if (idx_last) state_nxt = mid_r ? S_M_RD : S_C_RD;
      S_C_RD:  state_nxt = S_C_Y;
      S_C_Y:   state_nxt = tgt_ok ? S_C_MK : (idx_last ? S_DONE : S_C_RD);
      S_C_MK:  state_nxt = idx_last ? S_DONE : S_C_RD;
      S_M_RD:  state_nxt = S_M_Y;
      S_M_Y:   state_nxt = tgt_ok ? S_M_MN : mid_adv_st;
      S_M_MN: begin
        if (mark_s == 0) begin
          state_nxt = mid_adv_st;
        end else if (split_hit) begin
          state_nxt = (too_many || store_full) ? S_DONE : S_M_SPL;
        end else begin
          state_nxt = mid_adv_st;
        end
      end
      S_M_SPL:  state_nxt = append_r ? mid_adv_st : S_M_SRCH;
      S_M_SRCH: state_nxt = (j_r == n2_r) ? mid_adv_st : S_M_SCMP;
      S_M_SCMP: state_nxt = srch_hit ? mid_adv_st : S_M_SRCH;
      S_CP_SRC: state_nxt = S_CP_SW;
      S_CP_SW:  state_nxt = S_CP_RD;
      S_CP_RD:  state_nxt = S_CP_WR;
      S_CP_WR: begin
        if (!cp_last_i) begin
          state_nxt = S_CP_RD;
        end else begin
          state_nxt = cp_last_k ? p3_start_st : S_CP_SRC;
        end
      end
      S_P3_LST: state_nxt = S_P3_P;
      S_P3_P:   state_nxt = p_ok ? S_P3_V : (lst_last ? S_COMMIT : S_P3_LST);
      S_P3_V:   state_nxt = tgt_ok ? S_P3_A : (lst_last ? S_COMMIT : S_P3_LST);
      S_P3_A:   state_nxt = (mark_s > 1) ? S_P3_B : (lst_last ? S_COMMIT : S_P3_LST);
      S_P3_B:   state_nxt = lst_last ? S_COMMIT : S_P3_LST;
      S_COMMIT: state_nxt = S_DONE;
      S_F_LST:  state_nxt = S_F_WR;
      S_F_WR:   state_nxt = lst_last ? S_DONE : S_F_LST;
      S_DONE:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    tbl_re = 1'b0;  tbl_we = 1'b0;  tbl_addr = '0;  tbl_wdata = '0;
    mark_re = 1'b0; mark_we = 1'b0; mark_addr = '0; mark_wdata = '0;
    list_re = 1'b0; list_we = 1'b0; list_addr = '0; list_wdata = '0;
    split_re = 1'b0; split_we = 1'b0; split_addr = '0; split_wdata = '0;
    unique case (state_r)
      S_INIT: begin
        // rewrite column g with g+2, clear both mark banks on the way
        tbl_we    = 1'b1;
        tbl_addr  = sweep_r;
        tbl_wdata = ENT_W'(sweep_r[TBL_AW-1:ST_W]) + ENT_W'(2);
        mark_we   = 1'b1;
        mark_addr = sweep_r[MARK_AW-1:0];
      end
      S_RD: begin
        tbl_re   = 1'b1;
        tbl_addr = {g_r, row_r};
      end
      S_FL: begin
        tbl_we    = 1'b1;
        tbl_addr  = {g_r, idx_r[ST_W-1:0]};
        tbl_wdata = neg_rule;
      end
      S_CLR: begin
        mark_we   = 1'b1;
        mark_addr = {mid_r ? bank_n : bank_r, idx_r[ST_W-1:0]};
      end
      S_C_RD: begin
        tbl_re   = 1'b1;
        tbl_addr = {g_r, idx_r[ST_W-1:0]};
      end
      S_C_Y: begin
        mark_re   = tgt_ok;
        mark_addr = {bank_r, tbl_rd_r[ST_W-1:0] - ST_W'(1)};
      end
      S_C_MK: begin
        if (mark_s == 0) begin
          mark_we    = 1'b1;
          mark_addr  = {bank_r, y_r[ST_W-1:0] - ST_W'(1)};
          mark_wdata = MARK_W'(1);
          list_we    = 1'b1;
          list_addr  = {bank_r, len0_r[ST_W-1:0]};
          list_wdata = y_r[ST_W-1:0] - ST_W'(1);
        end
      end
      S_M_RD: begin
        tbl_re    = 1'b1;
        tbl_addr  = {g_r, idx_r[ST_W-1:0]};
        mark_re   = 1'b1;
        mark_addr = {bank_r, idx_r[ST_W-1:0]};
      end
      S_M_Y: begin
        mark_re   = tgt_ok;
        mark_addr = {bank_n, tbl_rd_r[ST_W-1:0] - ST_W'(1)};
      end
      S_M_MN: begin
        if (mark_s == 0) begin
          mark_we    = 1'b1;
          mark_addr  = {bank_n, y_r[ST_W-1:0] - ST_W'(1)};
          mark_wdata = mc_r ? MARK_W'(1) : {MARK_W{1'b1}};
          list_we    = mc_r;
          list_addr  = {bank_n, n2_r[ST_W-1:0]};
          list_wdata = y_r[ST_W-1:0] - ST_W'(1);
        end else if (split_hit && !too_many && !store_full) begin
          // new state z copies y; mark z as on the path
          split_we    = 1'b1;
          split_addr  = nn_inc[SPL_AW-1:0];
          split_wdata = y_r[ST_W-1:0] - ST_W'(1);
          mark_we     = 1'b1;
          mark_addr   = {bank_n, z_sum[ST_W-1:0] - ST_W'(1)};
          mark_wdata  = MARK_W'(1);
        end
      end
      S_M_SPL: begin
        mark_we    = 1'b1;
        mark_addr  = {bank_n, y_r[ST_W-1:0] - ST_W'(1)};
        mark_wdata = MARK_W'(nn_r) + MARK_W'(1);
        list_we    = append_r;
        list_addr  = {bank_n, n2_r[ST_W-1:0]};
        list_wdata = z_r[ST_W-1:0] - ST_W'(1);
      end
      S_M_SRCH: begin
        list_re   = (j_r != n2_r);
        list_addr = {bank_n, j_r[ST_W-1:0]};
      end
      S_M_SCMP: begin
        list_we    = srch_hit;
        list_addr  = {bank_n, j_r[ST_W-1:0]};
        list_wdata = z_r[ST_W-1:0] - ST_W'(1);
      end
      S_CP_SRC: begin
        split_re   = 1'b1;
        split_addr = k_r[SPL_AW-1:0];
      end
      S_CP_RD: begin
        tbl_re   = 1'b1;
        tbl_addr = {ci_r[SYM_W-1:0], src_r};
      end
      S_CP_WR: begin
        tbl_we    = 1'b1;
        tbl_addr  = {ci_r[SYM_W-1:0], ns_r[ST_W-1:0] + ST_W'(k_r) - ST_W'(1)};
        tbl_wdata = tbl_rd_r;
      end
      S_P3_LST, S_F_LST: begin
        list_re   = 1'b1;
        list_addr = {bank_r, idx_r[ST_W-1:0]};
      end
      S_P3_P: begin
        tbl_re   = p_ok;
        tbl_addr = {g_r, list_rd_r};
      end
      S_P3_V: begin
        mark_re   = tgt_ok;
        mark_addr = {bank_n, tbl_rd_r[ST_W-1:0] - ST_W'(1)};
      end
      S_P3_A: begin
        if (mark_s > 1) begin
          tbl_we    = 1'b1;
          tbl_addr  = {g_r, p_r};
          tbl_wdata = ENT_W'(ns_r) + ENT_W'(mark_rd_r[NN_W-1:0]) - ENT_W'(1);
          mark_re   = 1'b1;
          mark_addr = {bank_n, p_r};
        end
      end
      S_P3_B: begin
        if (mark_s > 1) begin
          tbl_we    = 1'b1;
          tbl_addr  = {g_r, ns_r[ST_W-1:0] + ST_W'(mark_rd_r[NN_W-1:0]) - ST_W'(2)};
          tbl_wdata = ENT_W'(ns_r) + ENT_W'(a_r);
        end
      end
      S_F_WR: begin
        tbl_we    = 1'b1;
        tbl_addr  = {g_r, list_rd_r};
        tbl_wdata = neg_rule;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_addr] <= tbl_wdata;
    if (tbl_re) tbl_rd_r <= tbl_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_addr] <= mark_wdata;
    if (mark_re) mark_rd_r <= mark_mem[mark_addr];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_addr] <= list_wdata;
    if (list_re) list_rd_r <= list_mem[list_addr];
  end

  always_ff @(posedge clk) begin
    if (split_we) split_mem[split_addr] <= split_wdata;
    if (split_re) split_rd_r <= split_mem[split_addr];
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      init_req_r  <= 1'b0;
      num_sym_r   <= SYMF_W'(2);
      ns_r        <= '0;
      err_r       <= STAT_OK;
      len0_r      <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) num_sym_r <= cfg_wr_data;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_INIT: begin
          sweep_r <= sweep_r + TBL_AW'(1);
          if (sweep_last) begin
            ns_r   <= CNT_W'(nsym) + CNT_W'(1);
            err_r  <= STAT_OK;
            len0_r <= '0;
            bank_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            g_r        <= in_sym[SYM_W-1:0] - SYM_W'(1);
            row_r      <= in_row[ST_W-1:0] - ST_W'(1);
            rule_r     <= in_rule;
            mid_r      <= !in_first;
            entry_r    <= '0;
            idx_r      <= '0;
            nn_r       <= '0;
            n2_r       <= '0;
            k_r        <= NN_W'(1);
            sweep_r    <= '0;
            init_req_r <= (in_req == REQ_REINIT);
          end
        end
        S_RD_W: entry_r <= tbl_rd_r;
        S_FL:   idx_r <= idx_r + CNT_W'(1);
        S_CLR: begin
          idx_r <= idx_last ? '0 : idx_r + CNT_W'(1);
          if (!mid_r) len0_r <= '0;
        end
        S_C_Y: begin
          if (tgt_ok) y_r <= tbl_rd_r[CNT_W-1:0];
          else        idx_r <= idx_r + CNT_W'(1);
        end
        S_C_MK: begin
          if (mark_s == 0) len0_r <= len0_r + CNT_W'(1);
          idx_r <= idx_r + CNT_W'(1);
        end
        S_M_Y: begin
          mc_r <= (mark_s == 1);
          if (tgt_ok) y_r <= tbl_rd_r[CNT_W-1:0];
          else        idx_r <= idx_last ? '0 : idx_r + CNT_W'(1);
        end
        S_M_MN: begin
          if (mark_s == 0) begin
            if (mc_r) n2_r <= n2_r + CNT_W'(1);
            idx_r <= idx_last ? '0 : idx_r + CNT_W'(1);
          end else if (split_hit) begin
            priority if (too_many) begin
              err_r <= STAT_MANY;
            end else if (store_full) begin
              err_r <= STAT_FULL;
            end else begin
              nn_r     <= nn_inc;
              z_r      <= z_sum[CNT_W-1:0];
              append_r <= (mark_s == -1);
            end
          end else begin
            idx_r <= idx_last ? '0 : idx_r + CNT_W'(1);
          end
        end
        S_M_SPL: begin
          if (append_r) begin
            n2_r  <= n2_r + CNT_W'(1);
            idx_r <= idx_last ? '0 : idx_r + CNT_W'(1);
          end else begin
            j_r <= '0;
          end
        end
        S_M_SRCH: if (j_r == n2_r) idx_r <= idx_last ? '0 : idx_r + CNT_W'(1);
        S_M_SCMP: begin
          if (srch_hit) idx_r <= idx_last ? '0 : idx_r + CNT_W'(1);
          else          j_r <= j_r + CNT_W'(1);
        end
        S_CP_SW: begin
          src_r <= split_rd_r;
          ci_r  <= '0;
        end
        S_CP_WR: begin
          if (cp_last_i) k_r <= k_r + NN_W'(1);
          else           ci_r <= ci_r + SYMF_W'(1);
        end
        S_P3_P: begin
          p_r <= list_rd_r;
          if (!p_ok) idx_r <= idx_r + CNT_W'(1);
        end
        S_P3_V: if (!tgt_ok) idx_r <= idx_r + CNT_W'(1);
        S_P3_A: begin
          a_r <= mark_rd_r[NN_W-1:0] - NN_W'(1);
          if (!(mark_s > 1)) idx_r <= idx_r + CNT_W'(1);
        end
        S_P3_B: idx_r <= idx_r + CNT_W'(1);
        S_COMMIT: begin
          ns_r   <= ns_r + CNT_W'(nn_r);
          bank_r <= bank_n;
          len0_r <= n2_r;
        end
        S_F_WR: idx_r <= idx_r + CNT_W'(1);
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_entry_r <= entry_r;
            out_cnt_r   <= ns_r;
            out_stat_r  <= err_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/sab_checker.sv =====
`default_nettype none
module sab_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [sab_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire [sab_pkg::OUT_USER_W-1:0]  out_tuser
);
  import sab_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one beat in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");

  // the automaton always has states
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ENT_W+CNT_W-1:ENT_W] != '0)
    else $error("state count of zero reported");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'b11)
    else $error("undefined status code");

endmodule

bind substring_automaton_builder sab_checker u_sab_checker (.*);
`default_nettype wire
